@@ hw/rtl/cabs_pkg.sv @@
package cabs_pkg;

    // Field widths
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int ACC_W        = 62;
    localparam int AREA_W       = 60;
    localparam int COUNT_W      = 13;
    localparam int MAX_VERTICES = 4096;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = 2 * COORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = AREA_W + 2 + COUNT_W + 4 * COORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation carried from front to back
    typedef enum logic [1:0] {
        KIND_START,
        KIND_KEEP,
        KIND_CLOSE
    } kind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        kind_t kind;
        vtx_t  vtx;
    } entry_t;

endpackage

@@ hw/rtl/cabs_front.sv @@
module cabs_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           opt_en,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cabs_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           q_push,
    output cabs_pkg::entry_t               q_entry
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIN1,
        ST_FIN2
    } state_t;

    state_t           state_reg, state_next;
    cabs_pkg::vtx_t   first_reg, first_next;
    cabs_pkg::vtx_t   kept_reg, kept_next;
    cabs_pkg::vtx_t   pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             in_contour_reg, in_contour_next;

    cabs_pkg::vtx_t   in_vtx;
    cabs_pkg::vtx_t   succ;
    logic signed [cabs_pkg::DIFF_W-1:0] ax, ay, bx, by;
    logic signed [cabs_pkg::PROD_W-1:0] cross_a, cross_b;
    logic             keep_pend;
    logic             accept;

    // Unpack the incoming vertex
    assign in_vtx.x = s_tdata[cabs_pkg::COORD_W-1:0];
    assign in_vtx.y = s_tdata[2*cabs_pkg::COORD_W-1:cabs_pkg::COORD_W];

    // Collinearity of pending vertex between last kept vertex and successor
    assign succ = (state_reg == ST_FIN1) ? first_reg : in_vtx;
    assign ax = $signed({pend_reg.x[cabs_pkg::COORD_W-1], pend_reg.x})
              - $signed({kept_reg.x[cabs_pkg::COORD_W-1], kept_reg.x});
    assign ay = $signed({pend_reg.y[cabs_pkg::COORD_W-1], pend_reg.y})
              - $signed({kept_reg.y[cabs_pkg::COORD_W-1], kept_reg.y});
    assign bx = $signed({succ.x[cabs_pkg::COORD_W-1], succ.x})
              - $signed({pend_reg.x[cabs_pkg::COORD_W-1], pend_reg.x});
    assign by = $signed({succ.y[cabs_pkg::COORD_W-1], succ.y})
              - $signed({pend_reg.y[cabs_pkg::COORD_W-1], pend_reg.y});
    assign cross_a = ax * by;
    assign cross_b = ay * bx;
    assign keep_pend = !(opt_en && (cross_a == cross_b));

    assign s_tready = (state_reg == ST_RUN) && !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the vertex and queue the resulting operation
    always_comb begin
        state_next      = state_reg;
        first_next      = first_reg;
        kept_next       = kept_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        in_contour_next = in_contour_reg;
        q_push          = 1'b0;
        q_entry.kind    = cabs_pkg::KIND_KEEP;
        q_entry.vtx     = pend_reg;
        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    if (!in_contour_reg) begin
                        first_next      = in_vtx;
                        kept_next       = in_vtx;
                        pend_valid_next = 1'b0;
                        in_contour_next = 1'b1;
                        q_push          = 1'b1;
                        q_entry.kind    = cabs_pkg::KIND_START;
                        q_entry.vtx     = in_vtx;
                        if (s_tlast) begin
                            state_next = ST_FIN2;
                        end
                    end else begin
                        if (pend_valid_reg && keep_pend) begin
                            q_push    = 1'b1;
                            kept_next = pend_reg;
                        end
                        pend_next       = in_vtx;
                        pend_valid_next = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_FIN1;
                        end
                    end
                end
            end
            ST_FIN1: begin
                // final vertex, tested against the first one as successor
                if (!q_full) begin
                    if (keep_pend) begin
                        q_push    = 1'b1;
                        kept_next = pend_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_FIN2;
                end
            end
            ST_FIN2: begin
                if (!q_full) begin
                    q_push          = 1'b1;
                    q_entry.kind    = cabs_pkg::KIND_CLOSE;
                    q_entry.vtx     = first_reg;
                    pend_valid_next = 1'b0;
                    in_contour_next = 1'b0;
                    state_next      = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            pend_valid_reg <= 1'b0;
            in_contour_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            in_contour_reg <= in_contour_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        kept_reg  <= kept_next;
        pend_reg  <= pend_next;
    end

endmodule

@@ hw/rtl/cabs_queue.sv @@
module cabs_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cabs_pkg::entry_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output cabs_pkg::entry_t head_data
);

    cabs_pkg::entry_t                 mem_reg [cabs_pkg::QUEUE_DEPTH];
    logic [cabs_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cabs_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cabs_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign full       = (count_reg == cabs_pkg::QCNT_W'(cabs_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == cabs_pkg::QPTR_W'(cabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == cabs_pkg::QPTR_W'(cabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/cabs_back.sv @@
module cabs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  cabs_pkg::entry_t                q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cabs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int W = cabs_pkg::COORD_W;

    // Operand stage tracking of the ring
    cabs_pkg::vtx_t  first_reg, first_next;
    cabs_pkg::vtx_t  kept_reg, kept_next;
    cabs_pkg::vtx_t  ref_vtx;

    // Pipeline stages
    logic                               s1_valid_reg, s1_valid_next;
    cabs_pkg::kind_t                    s1_kind_reg;
    cabs_pkg::vtx_t                     s1_vtx_reg;
    logic signed [cabs_pkg::DIFF_W-1:0] s1_dx_reg, s1_dx_next;
    logic signed [cabs_pkg::DIFF_W-1:0] s1_sy_reg, s1_sy_next;
    logic                               s2_valid_reg, s2_valid_next;
    cabs_pkg::kind_t                    s2_kind_reg;
    cabs_pkg::vtx_t                     s2_vtx_reg;
    logic signed [cabs_pkg::PROD_W-1:0] s2_prod_reg, s2_prod_next;

    // Accumulation state
    logic [cabs_pkg::ACC_W-1:0]   area_reg, area_next;
    logic signed [W-1:0]          left_reg, left_next, right_reg, right_next;
    logic signed [W-1:0]          bottom_reg, bottom_next, top_reg, top_next;
    logic [cabs_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         fin_reg, fin_next;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic [cabs_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                           adv;
    logic [cabs_pkg::ACC_W:0]       sum_w;
    logic [cabs_pkg::ACC_W-1:0]     sum_sat;
    logic [cabs_pkg::ACC_W-1:0]     abs_v;
    logic [cabs_pkg::AREA_W-1:0]    mag;
    logic [cabs_pkg::COUNT_W-1:0]   cnt_out;
    logic                           orient;
    logic                           inv;

    // Whole back end holds while a result waits
    assign adv   = !(out_valid_reg && !m_tready);
    assign q_pop = q_valid && adv;

    // Operand stage: edge term against kept vertex, closing edge uses first
    assign ref_vtx = (q_head.kind == cabs_pkg::KIND_CLOSE) ? first_reg : q_head.vtx;
    assign s1_dx_next = $signed({kept_reg.x[W-1], kept_reg.x})
                      - $signed({ref_vtx.x[W-1], ref_vtx.x});
    assign s1_sy_next = $signed({kept_reg.y[W-1], kept_reg.y})
                      + $signed({ref_vtx.y[W-1], ref_vtx.y});

    always_comb begin
        first_next = first_reg;
        kept_next  = kept_reg;
        if (q_pop) begin
            case (q_head.kind)
                cabs_pkg::KIND_START: begin
                    first_next = q_head.vtx;
                    kept_next  = q_head.vtx;
                end
                cabs_pkg::KIND_KEEP: begin
                    kept_next = q_head.vtx;
                end
                default: begin
                    kept_next = kept_reg;
                end
            endcase
        end
    end

    assign s1_valid_next = adv ? q_valid : s1_valid_reg;

    // Multiply stage
    assign s2_prod_next  = s1_dx_reg * s1_sy_reg;
    assign s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;

    // Saturating accumulate
    assign sum_w = {area_reg[cabs_pkg::ACC_W-1], area_reg}
                 + {{(cabs_pkg::ACC_W + 1 - cabs_pkg::PROD_W){s2_prod_reg[cabs_pkg::PROD_W-1]}},
                    s2_prod_reg};

    always_comb begin
        if (sum_w[cabs_pkg::ACC_W] != sum_w[cabs_pkg::ACC_W-1]) begin
            sum_sat = sum_w[cabs_pkg::ACC_W]
                    ? {1'b1, {(cabs_pkg::ACC_W-1){1'b0}}}
                    : {1'b0, {(cabs_pkg::ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_w[cabs_pkg::ACC_W-1:0];
        end
    end

    // Area, box and count update
    always_comb begin
        area_next   = area_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        top_next    = top_reg;
        count_next  = count_reg;
        fin_next    = fin_reg;
        if (adv) begin
            fin_next = 1'b0;
            if (s2_valid_reg) begin
                case (s2_kind_reg)
                    cabs_pkg::KIND_START: begin
                        area_next   = '0;
                        left_next   = s2_vtx_reg.x;
                        right_next  = s2_vtx_reg.x;
                        bottom_next = s2_vtx_reg.y;
                        top_next    = s2_vtx_reg.y;
                        count_next  = cabs_pkg::COUNT_W'(1);
                    end
                    cabs_pkg::KIND_KEEP: begin
                        area_next = sum_sat;
                        if (s2_vtx_reg.x < left_reg)   left_next   = s2_vtx_reg.x;
                        if (s2_vtx_reg.x > right_reg)  right_next  = s2_vtx_reg.x;
                        if (s2_vtx_reg.y < bottom_reg) bottom_next = s2_vtx_reg.y;
                        if (s2_vtx_reg.y > top_reg)    top_next    = s2_vtx_reg.y;
                        if (count_reg < cabs_pkg::COUNT_W'(cabs_pkg::MAX_VERTICES)) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    cabs_pkg::KIND_CLOSE: begin
                        area_next = sum_sat;
                        fin_next  = 1'b1;
                    end
                    default: begin
                        area_next = area_reg;
                    end
                endcase
            end
        end
    end

    // Summary formatting from the closed accumulator
    assign abs_v = area_reg[cabs_pkg::ACC_W-1]
                 ? (~area_reg + cabs_pkg::ACC_W'(1)) : area_reg;
    assign mag   = (|abs_v[cabs_pkg::ACC_W-1:cabs_pkg::AREA_W])
                 ? {cabs_pkg::AREA_W{1'b1}} : abs_v[cabs_pkg::AREA_W-1:0];
    assign cnt_out = (count_reg == cabs_pkg::COUNT_W'(1)) ? '0 : count_reg;
    assign orient  = (cnt_out > cabs_pkg::COUNT_W'(2));
    assign inv     = orient && area_reg[cabs_pkg::ACC_W-1];

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv) begin
            out_valid_next = fin_reg;
            if (fin_reg) begin
                out_data_next = cabs_pkg::OUT_TDATA_W'({top_reg, bottom_reg, right_reg,
                                                        left_reg, cnt_out, orient, inv,
                                                        mag});
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        kept_reg     <= kept_next;
        if (adv) begin
            s1_kind_reg <= q_head.kind;
            s1_vtx_reg  <= q_head.vtx;
            s1_dx_reg   <= s1_dx_next;
            s1_sy_reg   <= s1_sy_next;
            s2_kind_reg <= s1_kind_reg;
            s2_vtx_reg  <= s1_vtx_reg;
            s2_prod_reg <= s2_prod_next;
        end
        area_reg     <= area_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        bottom_reg   <= bottom_next;
        top_reg      <= top_next;
        count_reg    <= count_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ hw/rtl/contour_area_bbox_summary_core.sv @@
// Contour area and bounding-box summary. Vertices of one closed contour stream
// in on the s_ side, the final one flagged by s_tlast; one summary per contour
// leaves on the m_ side: twice the enclosed area (saturated shoelace magnitude),
// orientation, kept vertex count and bounding box. With optimize enabled
// (cfg_data bit written over the cfg_ channel while the block is idle),
// collinear vertices are dropped before they count. Rate: one vertex per cycle;
// the final vertex of a contour holds the input while the front classifier
// tests it against the first vertex (a single-vertex contour skips that test)
// and queues the closing edge; a full queue stretches that hold. The
// collinearity test in the front, a pair of 25x25 multiplies fed back into the
// kept-vertex register, sets the per-vertex cycle. The summary passes through
// a four-entry queue, a three-stage multiply-accumulate and the output
// register; a result held by m_tready stalls the back end and, once the queue
// fills, the input.
module contour_area_bbox_summary_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input vertices
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cabs_pkg::IN_TDATA_W-1:0]  s_tdata,  // vertex_x, vertex_y
    input  logic                            s_tlast,  // last_vertex
    // summaries
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // double_area, inverted, orientation_valid, kept_count,
    // box_left, box_right, box_bottom, box_top
    output logic [cabs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // optimize_enable register
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);

    logic             opt_reg, opt_next;
    logic             q_full;
    logic             q_push;
    cabs_pkg::entry_t q_entry;
    logic             q_valid;
    cabs_pkg::entry_t q_head;
    logic             q_pop;

    // Configuration register
    assign cfg_ready = 1'b1;
    assign opt_next  = (cfg_valid && cfg_ready) ? cfg_data : opt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opt_reg <= 1'b0;
        end else begin
            opt_reg <= opt_next;
        end
    end

    cabs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .opt_en   (opt_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    cabs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    cabs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/contour_area_bbox_summary_core_tb.sv @@
`timescale 1ns / 1ps

module contour_area_bbox_summary_core_tb;

    localparam int     COORD_W      = cabs_pkg::COORD_W;
    localparam int     AREA_W       = cabs_pkg::AREA_W;
    localparam int     COUNT_W      = cabs_pkg::COUNT_W;
    localparam int     MAX_VERTICES = cabs_pkg::MAX_VERTICES;
    localparam int     IN_TDATA_W   = cabs_pkg::IN_TDATA_W;
    localparam int     OUT_TDATA_W  = cabs_pkg::OUT_TDATA_W;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     SETTLE_TICKS = 12;
    localparam int     RANDOM_ITEMS = 500;
    localparam longint SUM_HI       = (64'sd1 <<< 61) - 1;
    localparam longint SUM_LO       = -(64'sd1 <<< 61);
    localparam longint AREA_MAX     = (64'sd1 <<< 60) - 1;
    localparam int     BOX_LSB      = AREA_W + 2 + COUNT_W;

    localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_ZERO = '0;
    localparam logic [COORD_W-1:0] C_NEG1 = '1;

    // Shape families for random contours
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_GRID,
        SHAPE_WALK,
        SHAPE_CORNERS
    } shape_t;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    typedef struct {
        logic [AREA_W-1:0]  area;
        logic               inverted;
        logic               orient_ok;
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] top;
    } summary_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data  = 1'b0;

    // Contour tracking state, mirrors the block
    bit       optimize_on;
    point_t   first_pt;
    point_t   kept_pt;
    point_t   pend_pt;
    bit       pend_ok;
    bit       open_contour;
    longint   shoelace;
    longint   box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    int       kept_n;

    summary_t summary_q[$];
    int       errors      = 0;
    int       cycle_count = 0;
    bit       s_gap_on    = 1'b1;

    contour_area_bbox_summary_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Shoelace accumulate with saturation at the accumulator limits
    function automatic void add_edge(point_t p, point_t c);
        longint s;
        s = shoelace + (p.x - c.x) * (p.y + c.y);
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        shoelace = s;
    endfunction

    function automatic void keep_point(point_t c);
        add_edge(kept_pt, c);
        if (c.x < box_lo_x) box_lo_x = c.x;
        if (c.x > box_hi_x) box_hi_x = c.x;
        if (c.y < box_lo_y) box_lo_y = c.y;
        if (c.y > box_hi_y) box_hi_y = c.y;
        if (kept_n < MAX_VERTICES) kept_n++;
        kept_pt = c;
    endfunction

    // Held vertex is dropped when collinear with kept predecessor and successor
    function automatic void settle_pending(point_t succ);
        longint cross_v;
        cross_v = (pend_pt.x - kept_pt.x) * (succ.y - pend_pt.y)
                - (pend_pt.y - kept_pt.y) * (succ.x - pend_pt.x);
        pend_ok = 1'b0;
        if (!(optimize_on && cross_v == 0)) keep_point(pend_pt);
    endfunction

    // Update contour state for one accepted vertex; queue a summary on close
    function automatic void fold_vertex(logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy,
                                        bit last);
        logic signed [COORD_W-1:0] sx, sy;
        point_t   v;
        summary_t s;
        longint   mag;
        int       cnt;
        sx  = vx;
        sy  = vy;
        v.x = sx;
        v.y = sy;
        if (!open_contour) begin
            first_pt     = v;
            kept_pt      = v;
            box_lo_x     = v.x;
            box_hi_x     = v.x;
            box_lo_y     = v.y;
            box_hi_y     = v.y;
            shoelace     = 0;
            kept_n       = 1;
            pend_ok      = 1'b0;
            open_contour = 1'b1;
        end else begin
            if (pend_ok) settle_pending(v);
            pend_pt = v;
            pend_ok = 1'b1;
        end
        if (!last) return;

        // closing edge back to the first vertex
        if (pend_ok) settle_pending(first_pt);
        add_edge(kept_pt, first_pt);
        cnt = (kept_n == 1) ? 0 : kept_n;
        mag = (shoelace < 0) ? -shoelace : shoelace;
        if (mag > AREA_MAX) mag = AREA_MAX;
        s.area      = mag[AREA_W-1:0];
        s.orient_ok = (cnt > 2);
        s.inverted  = s.orient_ok && (shoelace < 0);
        s.count     = cnt[COUNT_W-1:0];
        s.left      = box_lo_x[COORD_W-1:0];
        s.right     = box_hi_x[COORD_W-1:0];
        s.bottom    = box_lo_y[COORD_W-1:0];
        s.top       = box_hi_y[COORD_W-1:0];
        summary_q.push_back(s);

        pend_ok      = 1'b0;
        open_contour = 1'b0;
        shoelace     = 0;
        box_lo_x     = 0;
        box_hi_x     = 0;
        box_lo_y     = 0;
        box_hi_y     = 0;
        kept_n       = 0;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid possibly
    // still high, so back-to-back transfers never drop valid in between
    task automatic send_vertex(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                               input bit last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fold_vertex(vx, vy, last);
        @(negedge aclk);
        gap = s_gap_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop sending and let every pending summary drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (summary_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_optimize(input bit value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        optimize_on = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Single-vertex contours at the coordinate extremes and a two-vertex contour
    task automatic test_tiny_contours();
        write_optimize(1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(C_MAX, C_MIN, 1'b1);
        send_vertex(C_ZERO, C_ZERO, 1'b0);
        send_vertex(24'd3, 24'd4, 1'b1);
    endtask

    // Full-range square in both directions
    task automatic test_square_extremes();
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b1);
    endtask

    // Collinear removal, including the final vertex against the first and
    // contours where only the first vertex survives
    task automatic test_collinear_drop();
        write_optimize(1'b1);
        send_vertex(24'd0,  24'd0,  1'b0);
        send_vertex(24'd5,  24'd0,  1'b0);
        send_vertex(24'd10, 24'd0,  1'b0);
        send_vertex(24'd10, 24'd10, 1'b0);
        send_vertex(24'd0,  24'd10, 1'b0);
        send_vertex(24'd0,  24'd5,  1'b1);
        send_vertex(24'd0,  24'd0,  1'b0);
        send_vertex(24'd1,  24'd1,  1'b0);
        send_vertex(24'd2,  24'd2,  1'b1);
        send_vertex(C_NEG1, C_NEG1, 1'b0);
        send_vertex(24'd3,  24'd4,  1'b1);
    endtask

    // Random contours of mixed shape, mostly short
    task automatic test_random_contours();
        int     sent, len, n, wx, wy, dx, dy;
        shape_t shape;
        logic [COORD_W-1:0] vx, vy;
        logic [COORD_W-1:0] corner [4];
        corner[0] = C_MIN;
        corner[1] = C_MAX;
        corner[2] = C_ZERO;
        corner[3] = C_NEG1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) write_optimize(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 11) == 0) wait_idle();
            s_gap_on = ($urandom_range(0, 3) != 0);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(1, 12);
            shape = shape_t'($urandom_range(0, 3));
            wx    = $urandom_range(0, 20) - 10;
            wy    = $urandom_range(0, 20) - 10;
            dx    = $urandom_range(0, 4) - 2;
            dy    = $urandom_range(0, 4) - 2;
            for (n = 0; n < len; n++) begin
                case (shape)
                    SHAPE_WIDE: begin
                        vx = COORD_W'($urandom);
                        vy = COORD_W'($urandom);
                    end
                    SHAPE_GRID: begin
                        vx = COORD_W'($urandom_range(0, 8) - 4);
                        vy = COORD_W'($urandom_range(0, 8) - 4);
                    end
                    SHAPE_WALK: begin
                        if ($urandom_range(0, 2) == 0) begin
                            dx = $urandom_range(0, 4) - 2;
                            dy = $urandom_range(0, 4) - 2;
                        end
                        wx += dx;
                        wy += dy;
                        vx = COORD_W'(wx);
                        vy = COORD_W'(wy);
                    end
                    default: begin
                        vx = corner[2'($urandom_range(0, 3))];
                        vy = corner[2'($urandom_range(0, 3))];
                    end
                endcase
                send_vertex(vx, vy, n == len - 1);
            end
            sent += len;
        end
        s_gap_on = 1'b1;
    endtask

    // Result side backpressure, with stretches of no stalling
    always @(negedge aclk) begin : drive_ready
        int hold_left;
        int stretch_left;
        bit stall_on;
        if (stretch_left == 0) begin
            stall_on     = ($urandom_range(0, 3) != 0);
            stretch_left = $urandom_range(20, 300);
        end else begin
            stretch_left--;
        end
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= 1'b1;
            if (stall_on) hold_left = pick_gap();
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each summary transfer with the oldest expected one
    always @(posedge aclk) begin : check_summary
        summary_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (summary_q.size() == 0) begin
                $display("%0t ns: unexpected summary, expected none, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = summary_q.pop_front();
                check_field("double_area", 64'(want.area), 64'(m_tdata[AREA_W-1:0]));
                check_field("inverted", 64'(want.inverted), 64'(m_tdata[AREA_W]));
                check_field("orientation_valid", 64'(want.orient_ok),
                            64'(m_tdata[AREA_W+1]));
                check_field("kept_count", 64'(want.count),
                            64'(m_tdata[AREA_W+2 +: COUNT_W]));
                check_field("box_left", 64'(want.left),
                            64'(m_tdata[BOX_LSB +: COORD_W]));
                check_field("box_right", 64'(want.right),
                            64'(m_tdata[BOX_LSB+COORD_W +: COORD_W]));
                check_field("box_bottom", 64'(want.bottom),
                            64'(m_tdata[BOX_LSB+2*COORD_W +: COORD_W]));
                check_field("box_top", 64'(want.top),
                            64'(m_tdata[BOX_LSB+3*COORD_W +: COORD_W]));
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_tiny_contours();
        test_square_extremes();
        test_collinear_drop();
        test_random_contours();
        wait_idle();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
